// ===== rtl/pfmc_pkg.sv =====
// Shared types, constants and tables for the person-follow motion controller.
// Depends on nothing; every other file refers to it by scoped names.
package pfmc_pkg;

    localparam int BRAKE_TABLE_DEPTH = 256;
    localparam int BRAKE_AW          = $clog2(BRAKE_TABLE_DEPTH);
    localparam int CORDIC_STEPS      = 16;
    localparam int SQRT_STEPS        = 19;
    localparam int DIV_STEPS         = 27;
    localparam int STEP_W            = 5;

    localparam logic [63:0] C_Q16   = 64'd82500;
    localparam logic [63:0] LN2_Q16 = 64'd45426;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

    typedef enum logic [1:0] {
        MODE_TRACK  = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MIN_DIST   = 3'd0,
        REG_GAIN_PROP  = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_MAX_ADV    = 3'd3,
        REG_ACCEL_DIST = 3'd4,
        REG_SEARCH_ROT = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ZERO   = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_TRACK  = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic              load;
        logic              sq;
        logic              sum;
        logic              init;
        logic              iter;
        logic              dinit;
        logic              div;
        logic              mul_a;
        logic              mul_b;
        logic              rot;
        logic              brk;
        logic              adv1;
        logic              adv2;
        logic              out_load;
        logic              sel_near;
        logic [STEP_W-1:0] step;
        out_kind_t         kind;
        mode_t             nm;
    } cmd_t;

    typedef struct packed {
        logic near_far;
        logic goal_close;
    } status_t;

    localparam logic signed [19:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
        20'sd16, 20'sd8, 20'sd4, 20'sd2
    };

    typedef logic [12:0] brake_tab_t [BRAKE_TABLE_DEPTH];

    // exp(-4*ln(1/0.73)*x^2) in Q.12, series on the remainder after ln2 steps
    function automatic logic [12:0] brake_entry(input int unsigned i);
        logic [63:0] xq;
        logic [63:0] y;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rnd;
        xq   = (64'(i) << 15) / BRAKE_TABLE_DEPTH;
        y    = (C_Q16 * (xq * xq) + (64'd1 << 23)) >> 24;
        k    = y / LN2_Q16;
        r    = y - k * LN2_Q16;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        term = term * r / 64'd65536;  sum = sum - term;
        term = term * r / 64'd131072; sum = sum + term;
        term = term * r / 64'd196608; sum = sum - term;
        term = term * r / 64'd262144; sum = sum + term;
        term = term * r / 64'd327680; sum = sum - term;
        term = term * r / 64'd393216; sum = sum + term;
        term = term * r / 64'd458752; sum = sum - term;
        term = term * r / 64'd524288; sum = sum + term;
        term = term * r / 64'd589824; sum = sum - term;
        term = term * r / 64'd655360; sum = sum + term;
        term = term * r / 64'd720896; sum = sum - term;
        term = term * r / 64'd786432; sum = sum + term;
        if (k >= 64'd40) begin
            return 13'd0;
        end
        sum = sum >> k;
        rnd = (sum + (64'd1 << 17)) >> 18;
        return rnd[12:0];
    endfunction

    function automatic brake_tab_t brake_build();
        brake_tab_t t;
        for (int i = 0; i < BRAKE_TABLE_DEPTH; i++) begin
            t[i] = brake_entry(i);
        end
        return t;
    endfunction

    localparam brake_tab_t BRAKE_TAB = brake_build();

endpackage

// ===== rtl/pfmc_ctrl.sv =====
// Sequencer of the person-follow controller: mode state, handshakes, step counts.
// Depends on pfmc_pkg; drives pfmc_dp through cmd_t and reads status_t.
module pfmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               path_present,
    input  logic               stop_pressed,
    output logic               out_valid,
    input  logic               out_ready,
    input  pfmc_pkg::status_t  status,
    output pfmc_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SUM, ST_DEC, ST_ITER, ST_DINIT, ST_DIV,
        ST_MULA, ST_MULB, ST_ROT, ST_BRK, ST_ADV1, ST_ADV2, ST_OUT
    } state_t;

    state_t                       state_reg;
    pfmc_pkg::mode_t              mode_reg;
    pfmc_pkg::mode_t              emode_reg;
    pfmc_pkg::mode_t              nm_reg;
    pfmc_pkg::out_kind_t          kind_reg;
    logic [pfmc_pkg::STEP_W-1:0]  cnt_reg;
    logic                         out_valid_reg;
    logic                         accept;
    logic                         send;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign send      = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.sq       = (state_reg == ST_SQ);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.init     = (state_reg == ST_DEC);
        cmd.iter     = (state_reg == ST_ITER);
        cmd.dinit    = (state_reg == ST_DINIT);
        cmd.div      = (state_reg == ST_DIV);
        cmd.mul_a    = (state_reg == ST_MULA);
        cmd.mul_b    = (state_reg == ST_MULB);
        cmd.rot      = (state_reg == ST_ROT);
        cmd.brk      = (state_reg == ST_BRK);
        cmd.adv1     = (state_reg == ST_ADV1);
        cmd.adv2     = (state_reg == ST_ADV2);
        cmd.out_load = send;
        cmd.sel_near = (emode_reg == pfmc_pkg::MODE_WAIT);
        cmd.step     = cnt_reg;
        cmd.kind     = kind_reg;
        cmd.nm       = nm_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= pfmc_pkg::MODE_TRACK;
            emode_reg     <= pfmc_pkg::MODE_TRACK;
            nm_reg        <= pfmc_pkg::MODE_TRACK;
            kind_reg      <= pfmc_pkg::KIND_ZERO;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg <= pfmc_pkg::KIND_ZERO;
                        if (stop_pressed) begin
                            nm_reg    <= pfmc_pkg::MODE_STOP;
                            state_reg <= ST_OUT;
                        end
                        else if (!path_present) begin
                            nm_reg    <= pfmc_pkg::MODE_SEARCH;
                            kind_reg  <= pfmc_pkg::KIND_SEARCH;
                            state_reg <= ST_OUT;
                        end
                        else if (mode_reg == pfmc_pkg::MODE_STOP ||
                                 mode_reg == pfmc_pkg::MODE_SEARCH) begin
                            nm_reg    <= pfmc_pkg::MODE_TRACK;
                            state_reg <= ST_OUT;
                        end
                        else begin
                            emode_reg <= mode_reg;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:  state_reg <= ST_SUM;
                ST_SUM: state_reg <= ST_DEC;
                ST_DEC: begin
                    cnt_reg <= '0;
                    if (emode_reg == pfmc_pkg::MODE_WAIT) begin
                        nm_reg    <= status.near_far ? pfmc_pkg::MODE_TRACK
                                                     : pfmc_pkg::MODE_WAIT;
                        state_reg <= ST_OUT;
                    end
                    else if (status.goal_close) begin
                        nm_reg    <= pfmc_pkg::MODE_WAIT;
                        state_reg <= ST_OUT;
                    end
                    else begin
                        nm_reg    <= pfmc_pkg::MODE_TRACK;
                        kind_reg  <= pfmc_pkg::KIND_TRACK;
                        state_reg <= ST_ITER;
                    end
                end
                ST_ITER: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pfmc_pkg::STEP_W'(pfmc_pkg::SQRT_STEPS - 1)) begin
                        state_reg <= ST_DINIT;
                    end
                end
                ST_DINIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pfmc_pkg::STEP_W'(pfmc_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_MULA;
                    end
                end
                ST_MULA: state_reg <= ST_MULB;
                ST_MULB: state_reg <= ST_ROT;
                ST_ROT:  state_reg <= ST_BRK;
                ST_BRK:  state_reg <= ST_ADV1;
                ST_ADV1: state_reg <= ST_ADV2;
                ST_ADV2: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (send) begin
                        out_valid_reg <= 1'b1;
                        mode_reg      <= nm_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pfmc_dp.sv =====
// Datapath of the person-follow controller: config registers, squares, CORDIC,
// square root, ramp divider, PD law, brake lookup. Depends on pfmc_pkg.
module pfmc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pfmc_pkg::cmd_t      cmd,
    output pfmc_pkg::status_t   status,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic signed [14:0]  near_x,
    input  logic signed [14:0]  near_y,
    input  logic signed [14:0]  heading_x,
    input  logic signed [14:0]  heading_y,
    input  logic signed [14:0]  goal_x,
    input  logic signed [14:0]  goal_y,
    output logic [11:0]         adv_speed,
    output logic signed [15:0]  rot_rate,
    output logic [1:0]          mode_out
);

    logic [13:0]        min_dist_reg;
    logic [15:0]        gain_prop_reg;
    logic [15:0]        gain_deriv_reg;
    logic [11:0]        max_adv_reg;
    logic [15:0]        accel_reg;
    logic signed [15:0] search_rot_reg;
    logic signed [15:0] prev_reg;

    logic signed [14:0] nx_reg, ny_reg, hx_reg, hy_reg, gx_reg, gy_reg;
    logic [29:0]        sqa_reg, sqb_reg;
    logic [28:0]        sqt_reg;
    logic [30:0]        sum2_reg;

    logic signed [27:0] cx_reg, cy_reg;
    logic signed [19:0] cz_reg;
    logic               hzero_reg;
    logic [37:0]        sv_reg;
    logic [20:0]        srem_reg;
    logic [18:0]        root_reg;

    logic [26:0]        dn_reg;
    logic [15:0]        drem_reg;
    logic [26:0]        q_reg;

    logic signed [32:0] prod_p_reg;
    logic signed [33:0] prod_d_reg;
    logic signed [15:0] rot_res_reg;
    logic [12:0]        brake_reg;
    logic [24:0]        m1_reg;
    logic [11:0]        adv_res_reg;

    logic [11:0]        adv_out_reg;
    logic signed [15:0] rot_out_reg;
    logic [1:0]         mode_out_reg;

    logic signed [14:0] opa, opb;
    logic signed [15:0] thr;
    logic signed [19:0] zr;
    logic signed [15:0] e_w;
    logic signed [27:0] ix, iy;
    logic signed [19:0] iz;
    logic signed [27:0] dx, dy;
    logic [22:0]        rem_s, trial;
    logic [15:0]        acc_eff;
    logic [16:0]        drem_s;
    logic signed [20:0] num_c;
    logic [12:0]        ramp;
    logic signed [16:0] ed;
    logic signed [34:0] rsum;
    logic signed [22:0] rsh;
    logic signed [15:0] rsat;
    logic [16:0]        rabs;
    logic [16+pfmc_pkg::BRAKE_AW:0] idx_full;
    logic [pfmc_pkg::BRAKE_AW-1:0]  bidx;
    logic [37:0]        advp;

    // operand choice: near point for the wait test, goal point otherwise
    assign opa = cmd.sel_near ? nx_reg : gx_reg;
    assign opb = cmd.sel_near ? ny_reg : gy_reg;
    assign thr = cmd.sel_near ? $signed({2'b00, min_dist_reg}) + 16'sd100
                              : $signed({2'b00, min_dist_reg}) - 16'sd100;

    assign status.near_far   = (sum2_reg > {2'b00, sqt_reg});
    assign status.goal_close = (min_dist_reg > 14'd100) && (sum2_reg < {2'b00, sqt_reg});

    assign zr  = cz_reg + 20'sd8;
    assign e_w = hzero_reg ? 16'sd0 : 16'(zr >>> 4);

    // quadrant fold into the right half plane
    always_comb begin
        ix = 28'(hy_reg);
        iy = 28'(hx_reg);
        iz = '0;
        if (hy_reg < 0) begin
            if (hx_reg >= 0) begin
                ix = 28'(hx_reg);
                iy = -28'(hy_reg);
                iz = pfmc_pkg::HALF_PI_Q16;
            end
            else begin
                ix = -28'(hx_reg);
                iy = 28'(hy_reg);
                iz = -pfmc_pkg::HALF_PI_Q16;
            end
        end
    end

    assign dx     = cy_reg >>> cmd.step[3:0];
    assign dy     = cx_reg >>> cmd.step[3:0];
    assign rem_s  = {srem_reg, sv_reg[37:36]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign acc_eff = (accel_reg == 16'd0) ? 16'd1 : accel_reg;
    assign drem_s = {drem_reg, dn_reg[26]};
    assign num_c  = $signed({2'b00, root_reg}) + 21'sd1600
                  - $signed({3'b000, min_dist_reg, 4'b0000});
    assign ramp   = (q_reg > 27'd4096) ? 13'd4096 : q_reg[12:0];
    assign ed     = $signed({e_w[15], e_w}) - $signed({prev_reg[15], prev_reg});
    assign rsum   = 35'(prod_p_reg) + 35'(prod_d_reg) + 35'sd2048;
    assign rsh    = 23'(rsum >>> 12);

    always_comb begin
        if (rsh > 23'sd32767) begin
            rsat = 16'sd32767;
        end
        else if (rsh < -23'sd32768) begin
            rsat = -16'sd32768;
        end
        else begin
            rsat = 16'(rsh);
        end
    end

    assign rabs     = (rot_res_reg < 0) ? 17'(-$signed({rot_res_reg[15], rot_res_reg}))
                                        : {1'b0, rot_res_reg};
    assign idx_full = ((17 + pfmc_pkg::BRAKE_AW)'(rabs)
                       * (17 + pfmc_pkg::BRAKE_AW)'(pfmc_pkg::BRAKE_TABLE_DEPTH)) >> 15;
    assign bidx     = (idx_full > (17 + pfmc_pkg::BRAKE_AW)'(pfmc_pkg::BRAKE_TABLE_DEPTH - 1))
                    ? pfmc_pkg::BRAKE_AW'(pfmc_pkg::BRAKE_TABLE_DEPTH - 1)
                    : idx_full[pfmc_pkg::BRAKE_AW-1:0];
    assign advp     = 38'(m1_reg) * 38'(ramp) + 38'd8388608;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_dist_reg   <= 14'd800;
            gain_prop_reg  <= 16'd4096;
            gain_deriv_reg <= 16'd2048;
            max_adv_reg    <= 12'd1000;
            accel_reg      <= 16'd1500;
            search_rot_reg <= 16'sd2048;
            prev_reg       <= '0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pfmc_pkg::REG_MIN_DIST:   min_dist_reg   <= cfg_data[13:0];
                    pfmc_pkg::REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    pfmc_pkg::REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    pfmc_pkg::REG_MAX_ADV:    max_adv_reg    <= cfg_data[11:0];
                    pfmc_pkg::REG_ACCEL_DIST: accel_reg      <= cfg_data;
                    pfmc_pkg::REG_SEARCH_ROT: search_rot_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.rot) begin
                prev_reg <= e_w;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            nx_reg <= near_x;
            ny_reg <= near_y;
            hx_reg <= heading_x;
            hy_reg <= heading_y;
            gx_reg <= goal_x;
            gy_reg <= goal_y;
        end
        if (cmd.sq) begin
            sqa_reg <= 30'(opa * opa);
            sqb_reg <= 30'(opb * opb);
            sqt_reg <= 29'(thr * thr);
        end
        if (cmd.sum) begin
            sum2_reg <= 31'(sqa_reg) + 31'(sqb_reg);
        end
        if (cmd.init) begin
            cx_reg    <= ix <<< 10;
            cy_reg    <= iy <<< 10;
            cz_reg    <= iz;
            hzero_reg <= (hx_reg == 0) && (hy_reg == 0);
            sv_reg    <= {sum2_reg[29:0], 8'd0};
            srem_reg  <= '0;
            root_reg  <= '0;
        end
        if (cmd.iter) begin
            if (!cmd.step[4]) begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + pfmc_pkg::ATAN_Q16[cmd.step[3:0]];
                end
                else begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - pfmc_pkg::ATAN_Q16[cmd.step[3:0]];
                end
            end
            sv_reg <= sv_reg << 2;
            if (rem_s >= trial) begin
                srem_reg <= 21'(rem_s - trial);
                root_reg <= {root_reg[17:0], 1'b1};
            end
            else begin
                srem_reg <= rem_s[20:0];
                root_reg <= {root_reg[17:0], 1'b0};
            end
        end
        if (cmd.dinit) begin
            dn_reg   <= (num_c < 0) ? 27'd0 : {num_c[18:0], 8'd0};
            drem_reg <= '0;
            q_reg    <= '0;
        end
        if (cmd.div) begin
            dn_reg <= dn_reg << 1;
            if (drem_s >= {1'b0, acc_eff}) begin
                drem_reg <= 16'(drem_s - {1'b0, acc_eff});
                q_reg    <= {q_reg[25:0], 1'b1};
            end
            else begin
                drem_reg <= drem_s[15:0];
                q_reg    <= {q_reg[25:0], 1'b0};
            end
        end
        if (cmd.mul_a) begin
            prod_p_reg <= $signed({1'b0, gain_prop_reg}) * e_w;
        end
        if (cmd.mul_b) begin
            prod_d_reg <= $signed({1'b0, gain_deriv_reg}) * ed;
        end
        if (cmd.rot) begin
            rot_res_reg <= rsat;
        end
        if (cmd.brk) begin
            brake_reg <= pfmc_pkg::BRAKE_TAB[bidx];
        end
        if (cmd.adv1) begin
            m1_reg <= 25'(max_adv_reg) * 25'(brake_reg);
        end
        if (cmd.adv2) begin
            adv_res_reg <= advp[35:24];
        end
        if (cmd.out_load) begin
            mode_out_reg <= cmd.nm;
            case (cmd.kind)
                pfmc_pkg::KIND_TRACK: begin
                    adv_out_reg <= adv_res_reg;
                    rot_out_reg <= rot_res_reg;
                end
                pfmc_pkg::KIND_SEARCH: begin
                    adv_out_reg <= '0;
                    rot_out_reg <= search_rot_reg;
                end
                default: begin
                    adv_out_reg <= '0;
                    rot_out_reg <= '0;
                end
            endcase
        end
    end

    assign adv_speed = adv_out_reg;
    assign rot_rate  = rot_out_reg;
    assign mode_out  = mode_out_reg;

endmodule

// ===== rtl/person_follow_motion_controller_top.sv =====
// Top level of the person-follow motion controller.
// Depends on pfmc_pkg, pfmc_ctrl and pfmc_dp.
//
// Usage:
//   One input word per control tick on the in_valid/in_ready channel: path and
//   stop flags and the near, heading and goal points in mm (robot frame).
//   One result word per input on out_valid/out_ready: advance speed (mm/s),
//   rotation speed (Q3.12 rad/s, saturated) and the new mode.
//   Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
//   0..5 and cfg_data; write them only while the block is idle.
// Sequence:
//   Stop, search and mode-return ticks go straight to output; wait decisions
//   first form the squares and their sum. A tracking tick runs, on the shared
//   iteration counter, 19 steps of the square-root unit (the 16 CORDIC steps
//   run beside it), 27 of the restoring ramp divider, then the PD multiplies,
//   brake lookup and two advance multiplies. One word is in flight at a time.
// Reset:
//   Mode returns to track, the previous angle error clears and registers take
//   their default values; no word is pending afterwards.
// Stall:
//   A finished word sits in the output register; a new input is taken while it
//   waits, and the next result holds in the sequencer until the register frees.
module person_follow_motion_controller_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               path_present,
    input  logic               stop_pressed,
    input  logic signed [14:0] near_x,
    input  logic signed [14:0] near_y,
    input  logic signed [14:0] heading_x,
    input  logic signed [14:0] heading_y,
    input  logic signed [14:0] goal_x,
    input  logic signed [14:0] goal_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        adv_speed,
    output logic signed [15:0] rot_rate,
    output logic [1:0]         mode_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    pfmc_pkg::cmd_t    cmd;
    pfmc_pkg::status_t status;

    // registers accept a write in every cycle
    assign cfg_ready = 1'b1;

    pfmc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .path_present (path_present),
        .stop_pressed (stop_pressed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd)
    );

    pfmc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .near_x     (near_x),
        .near_y     (near_y),
        .heading_x  (heading_x),
        .heading_y  (heading_y),
        .goal_x     (goal_x),
        .goal_y     (goal_y),
        .adv_speed  (adv_speed),
        .rot_rate   (rot_rate),
        .mode_out   (mode_out)
    );

endmodule

// ===== rtl/pfmc_checker.sv =====
// Port-level checks for the person-follow controller, bound to the top level.
// Depends on pfmc_pkg and person_follow_motion_controller_top.
module pfmc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [11:0]        adv_speed,
    input logic signed [15:0] rot_rate,
    input logic [1:0]         mode_out
);

    // hold a stalled result word: valid, mode and advance speed stay
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode_out) && $stable(adv_speed))
        else $error("result word dropped or changed while stalled");

    // wait and stop never move the robot
    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode_out == pfmc_pkg::MODE_WAIT || mode_out == pfmc_pkg::MODE_STOP)
        |-> adv_speed == 12'd0 && rot_rate == 16'sd0)
        else $error("nonzero speed in wait or stop");

    // search only rotates
    a_search: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_out == pfmc_pkg::MODE_SEARCH |-> adv_speed == 12'd0)
        else $error("advance while searching");

    // one word in flight: input closes after an accept
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

endmodule

bind person_follow_motion_controller_top pfmc_checker u_pfmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .adv_speed (adv_speed),
    .rot_rate  (rot_rate),
    .mode_out  (mode_out)
);
